// ===== design/deq_pkg.sv =====
// Shared types, codes and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;

    localparam logic [REQ_W-1:0] REQ_DISPLAY    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
        logic                     last_of_run;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_WALK_START,
        OP_WALK_NEXT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                load_const;
        logic [STATUS_W-1:0] const_status;
        logic                load_rd;
        logic                rd_last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
        logic out_last;
    } stat_t;

endpackage

// ===== design/deq_ctrl.sv =====
// Request sequencer for the double-ended queue: handshakes and datapath commands.
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [deq_pkg::REQ_W-1:0]   req_type,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  deq_pkg::stat_t              stat,
    output deq_pkg::cmd_t               cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   disp_reg, disp_next;

    always_comb
    begin
        state_next       = state_reg;
        disp_next        = disp_reg;
        cmd.op           = deq_pkg::OP_NONE;
        cmd.load_const   = 1'b0;
        cmd.const_status = deq_pkg::ST_OK;
        cmd.load_rd      = 1'b0;
        cmd.rd_last      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    disp_next  = (req_type == deq_pkg::REQ_DISPLAY);
                    state_next = S_SEND;
                    case (req_type)
                        deq_pkg::REQ_DISPLAY:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_const   = 1'b1;
                                cmd.const_status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = deq_pkg::OP_WALK_START;
                                state_next = S_READ;
                            end
                        end
                        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK:
                        begin
                            cmd.load_const = 1'b1;
                            if (stat.full)
                            begin
                                cmd.const_status = deq_pkg::ST_FULL;
                            end
                            else if (req_type == deq_pkg::REQ_PUSH_FRONT)
                            begin
                                cmd.op = deq_pkg::OP_PUSH_FRONT;
                            end
                            else
                            begin
                                cmd.op = deq_pkg::OP_PUSH_BACK;
                            end
                        end
                        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_const   = 1'b1;
                                cmd.const_status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op = (req_type == deq_pkg::REQ_POP_FRONT) ?
                                         deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            // Unused codes leave the queue alone and answer ok.
                            cmd.load_const = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.load_rd = 1'b1;
                cmd.rd_last = disp_reg ? stat.walk_last : 1'b1;
                state_next  = S_SEND;
            end
            S_SEND:
            begin
                if (rsp_ready)
                begin
                    if (disp_reg && !stat.out_last)
                    begin
                        cmd.op     = deq_pkg::OP_WALK_NEXT;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            disp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            disp_reg  <= disp_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_SEND);

endmodule

// ===== design/deq_datapath.sv =====
// Ring storage, end pointers, fill count, display cursor and result register.
`timescale 1ns / 1ps

module deq_datapath #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [deq_pkg::DATA_W-1:0]  data_in,
    input  deq_pkg::cmd_t                      cmd,
    output deq_pkg::stat_t                     stat,
    output deq_pkg::rsp_t                      rsp
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        return (p == '0) ? PW'(CAPACITY - 1) : p - 1'b1;
    endfunction

    logic signed [deq_pkg::DATA_W-1:0] mem [CAPACITY];
    logic signed [deq_pkg::DATA_W-1:0] rdata_reg;

    logic [PW-1:0] front_reg, front_next;
    logic [PW-1:0] back_reg, back_next;
    logic [PW-1:0] walk_reg, walk_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] left_reg, left_next;
    logic          we;
    logic [PW-1:0] waddr;
    logic [PW-1:0] raddr;
    deq_pkg::rsp_t rsp_reg, rsp_next;

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        walk_next  = walk_reg;
        count_next = count_reg;
        left_next  = left_reg;
        we         = 1'b0;
        waddr      = back_reg;
        raddr      = front_reg;
        case (cmd.op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                we         = 1'b1;
                waddr      = ring_prev(front_reg);
                front_next = ring_prev(front_reg);
                count_next = count_reg + 1'b1;
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                we         = 1'b1;
                waddr      = back_reg;
                back_next  = ring_next(back_reg);
                count_next = count_reg + 1'b1;
            end
            deq_pkg::OP_POP_FRONT:
            begin
                raddr      = front_reg;
                front_next = ring_next(front_reg);
                count_next = count_reg - 1'b1;
            end
            deq_pkg::OP_POP_BACK:
            begin
                raddr      = ring_prev(back_reg);
                back_next  = ring_prev(back_reg);
                count_next = count_reg - 1'b1;
            end
            deq_pkg::OP_WALK_START:
            begin
                raddr     = front_reg;
                walk_next = front_reg;
                left_next = count_reg;
            end
            deq_pkg::OP_WALK_NEXT:
            begin
                raddr     = ring_next(walk_reg);
                walk_next = ring_next(walk_reg);
                left_next = left_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Occupancy always reports the count after the request has taken effect.
    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.load_const)
        begin
            rsp_next.data_out    = '0;
            rsp_next.status      = cmd.const_status;
            rsp_next.occupancy   = deq_pkg::OCC_W'(count_next);
            rsp_next.last_of_run = 1'b1;
        end
        else if (cmd.load_rd)
        begin
            rsp_next.data_out    = rdata_reg;
            rsp_next.status      = deq_pkg::ST_OK;
            rsp_next.occupancy   = deq_pkg::OCC_W'(count_next);
            rsp_next.last_of_run = cmd.rd_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= data_in;
        end
        rdata_reg <= mem[raddr];
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            walk_reg  <= '0;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            walk_reg  <= walk_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(CAPACITY));
    assign stat.walk_last = (left_reg == CW'(1));
    assign stat.out_last  = rsp_reg.last_of_run;
    assign rsp            = rsp_reg;

endmodule

// ===== design/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | deq_pkg::req_t (req_type, data_in)
//  rsp     | out       | rsp_valid/rsp_ready  | deq_pkg::rsp_t (data_out, status, occupancy,
//          |           |                      |   last_of_run)
//
// A push, a refused request or an unused code shows its word in the cycle after it is
// accepted; a pop's word passes through the registered read of the slot memory and
// then the result register. Display gives one word per element, each read again through
// the same memory read port and result register after the previous one is taken.
// A new request is taken the cycle after the last word of the previous one is taken.
// Reset clears the pointers and the count; the slot memory is not cleared.
// Holding rsp_ready low simply holds the current word; nothing is lost.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  deq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output deq_pkg::rsp_t  rsp
);

    deq_pkg::cmd_t  cmd;
    deq_pkg::stat_t stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req.req_type),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .data_in (req.data_in),
        .cmd     (cmd),
        .stat    (stat),
        .rsp     (rsp)
    );

endmodule

// ===== design/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound onto the top level.
`timescale 1ns / 1ps

module deq_checker #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input deq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input deq_pkg::rsp_t rsp
);

    // One request at a time: never ready for a new one while a word is offered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request ready while a result word is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready did not drop after a request was accepted");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result word changed or was withdrawn");

    a_refusal_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != deq_pkg::ST_OK) |->
        (rsp.last_of_run && rsp.data_out == '0))
        else $error("empty or full result is not a single zero word");

    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.occupancy) <= CAPACITY))
        else $error("occupancy exceeds capacity");

endmodule

bind double_ended_queue deq_checker #(
    .CAPACITY (CAPACITY)
) u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/sv/tb.sv =====
// Testbench for the double-ended queue: directed corner requests, then random traffic.
`timescale 1ns / 1ps

module tb;

    typedef logic [deq_pkg::REQ_W-1:0] kind_t;

    localparam int DEPTH = deq_pkg::CAPACITY_DEF;
    localparam kind_t REQ_UNUSED_LO = 3'd5;
    localparam kind_t REQ_UNUSED_HI = 3'd7;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    deq_pkg::req_t req_item = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    deq_pkg::rsp_t rsp_item;

    // Shadow copy of the queue contents and pointers.
    logic signed [deq_pkg::DATA_W-1:0] shadow_slots [DEPTH];
    int shadow_front = 0;
    int shadow_back = 0;
    int shadow_fill = 0;

    deq_pkg::rsp_t expected_words [$];
    int error_count = 0;
    bit steady = 1'b0;
    bit growing = 1'b1;

    double_ended_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_item)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        rsp_ready <= steady || ($urandom_range(99) >= 17);
    end

    // Works out the words one accepted request should produce and updates the shadow state.
    task automatic predict_request(input deq_pkg::req_t item);
        deq_pkg::rsp_t word;
        int i;
        word = '0;
        word.last_of_run = 1'b1;
        case (item.req_type)
            deq_pkg::REQ_DISPLAY:
            begin
                if (shadow_fill == 0)
                begin
                    word.status = deq_pkg::ST_EMPTY;
                    expected_words.push_back(word);
                end
                else
                begin
                    for (i = 0; i < shadow_fill; i++)
                    begin
                        word.data_out = shadow_slots[(shadow_front + i) % DEPTH];
                        word.status = deq_pkg::ST_OK;
                        word.occupancy = shadow_fill[deq_pkg::OCC_W-1:0];
                        word.last_of_run = (i == shadow_fill - 1);
                        expected_words.push_back(word);
                    end
                end
            end
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    word.status = deq_pkg::ST_FULL;
                end
                else
                begin
                    if (item.req_type == deq_pkg::REQ_PUSH_FRONT)
                    begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_slots[shadow_front] = item.data_in;
                    end
                    else
                    begin
                        shadow_slots[shadow_back] = item.data_in;
                        shadow_back = (shadow_back + 1) % DEPTH;
                    end
                    shadow_fill++;
                    word.status = deq_pkg::ST_OK;
                end
                word.occupancy = shadow_fill[deq_pkg::OCC_W-1:0];
                expected_words.push_back(word);
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK:
            begin
                if (shadow_fill == 0)
                begin
                    word.status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    if (item.req_type == deq_pkg::REQ_POP_FRONT)
                    begin
                        word.data_out = shadow_slots[shadow_front];
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end
                    else
                    begin
                        shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
                        word.data_out = shadow_slots[shadow_back];
                    end
                    shadow_fill--;
                    word.status = deq_pkg::ST_OK;
                end
                word.occupancy = shadow_fill[deq_pkg::OCC_W-1:0];
                expected_words.push_back(word);
            end
            default:
            begin
                word.status = deq_pkg::ST_OK;
                word.occupancy = shadow_fill[deq_pkg::OCC_W-1:0];
                expected_words.push_back(word);
            end
        endcase
    endtask

    // Valid is lowered only while idling, so a back-to-back request never sees two
    // assignments to it in one time step.
    task automatic send_request(input kind_t kind,
                                input logic signed [deq_pkg::DATA_W-1:0] value);
        deq_pkg::req_t item;
        item.req_type = kind;
        item.data_in = value;
        while (!steady && $urandom_range(99) < 17)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= item;
        do
            @(posedge clk);
        while (!req_ready);
        predict_request(item);
    endtask

    function automatic logic signed [deq_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_words.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected word: data %0d status %0d occ %0d last %0b",
                             rsp_item.data_out, rsp_item.status, rsp_item.occupancy,
                             rsp_item.last_of_run);
            end
            else
            begin
                deq_pkg::rsp_t want;
                want = expected_words.pop_front();
                if (rsp_item.data_out !== want.data_out || rsp_item.status !== want.status ||
                    rsp_item.occupancy !== want.occupancy ||
                    rsp_item.last_of_run !== want.last_of_run)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch: expected data %0d status %0d occ %0d last %0b,",
                                  " got data %0d status %0d occ %0d last %0b"},
                                 want.data_out, want.status, want.occupancy,
                                 want.last_of_run, rsp_item.data_out, rsp_item.status,
                                 rsp_item.occupancy, rsp_item.last_of_run);
                end
            end
        end
    end

    task automatic test_empty_queue();
        send_request(deq_pkg::REQ_DISPLAY, random_value());
        send_request(deq_pkg::REQ_POP_FRONT, random_value());
        send_request(deq_pkg::REQ_POP_BACK, random_value());
        send_request(REQ_UNUSED_LO, random_value());
        send_request(REQ_UNUSED_HI, random_value());
    endtask

    // Fills both ends, extreme values first, overflows the queue, then displays and pops it.
    task automatic test_fill_and_overflow();
        logic signed [deq_pkg::DATA_W-1:0] corner [4];
        int i;
        corner[0] = 32'sh8000_0000;
        corner[1] = 32'sh7fff_ffff;
        corner[2] = '0;
        corner[3] = -32'sd1;
        for (i = 0; i < DEPTH; i++)
            send_request(i % 2 ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_BACK,
                         i < 4 ? corner[i] : $urandom);
        send_request(deq_pkg::REQ_PUSH_FRONT, random_value());
        send_request(deq_pkg::REQ_PUSH_BACK, random_value());
        send_request(deq_pkg::REQ_DISPLAY, random_value());
        send_request(deq_pkg::REQ_POP_FRONT, random_value());
        send_request(deq_pkg::REQ_POP_BACK, random_value());
    endtask

    // Mostly pushes or mostly pops, switching direction after the queue has sat
    // full or empty for a while, so both boundaries are hit again and again.
    task automatic test_random_traffic(input int count);
        int k;
        int r;
        bit is_push;
        kind_t kind;
        for (k = 0; k < count; k++)
        begin
            if (growing && shadow_fill == DEPTH && $urandom_range(2) == 0)
                growing = 1'b0;
            else if (!growing && shadow_fill == 0 && $urandom_range(2) == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 3)
                growing = !growing;
            r = $urandom_range(99);
            if (r < 8)
                kind = deq_pkg::REQ_DISPLAY;
            else if (r < 11)
                kind = kind_t'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
            else
            begin
                is_push = ($urandom_range(99) < 80) ? growing : !growing;
                if (is_push)
                    kind = $urandom_range(1) ? deq_pkg::REQ_PUSH_FRONT
                                             : deq_pkg::REQ_PUSH_BACK;
                else
                    kind = $urandom_range(1) ? deq_pkg::REQ_POP_FRONT
                                             : deq_pkg::REQ_POP_BACK;
            end
            send_request(kind, random_value());
        end
    endtask

    task automatic test_no_gaps(input int count);
        steady = 1'b1;
        test_random_traffic(count);
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_and_overflow();
        test_random_traffic(220);
        test_no_gaps(60);
        test_random_traffic(220);
        req_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
